>>> hdl/segment_mean_level_quantizer_assert.svh
// Assertion macros shared by the level meter RTL.
`ifndef SEGMENT_MEAN_LEVEL_QUANTIZER_ASSERT_SVH
`define SEGMENT_MEAN_LEVEL_QUANTIZER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SMLQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slmq assertion failed (same-cycle check)");

// Next-cycle implication, checked on every clock edge out of reset.
`define SMLQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slmq assertion failed (next-cycle check)");

`endif

>>> hdl/slmq_pkg.sv
// Shared constants, types and register codes of the segment level meter.
package slmq_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int SUM_WIDTH    = 32;
  localparam int MEAN_WIDTH   = 16;
  localparam int LEVEL_WIDTH  = 4;
  localparam int DATA_WIDTH   = 16;
  localparam int NUM_LIMITS   = 7;
  localparam int INDEX_WIDTH  = 3;
  localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] SEG_LEN_RESET = COUNT_WIDTH'(1024);

  // Threshold reset values for levels two through eight.
  localparam logic [NUM_LIMITS-1:0][DATA_WIDTH-1:0] LIMIT_RESET = {
    16'sd800, 16'sd600, 16'sd500, 16'sd400, 16'sd300, 16'sd200, 16'sd50
  };

  // Configuration register indexes.
  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_SEGMENT_LENGTH    = 3'd0,
    REG_LIMIT_LEVEL_TWO   = 3'd1,
    REG_LIMIT_LEVEL_THREE = 3'd2,
    REG_LIMIT_LEVEL_FOUR  = 3'd3,
    REG_LIMIT_LEVEL_FIVE  = 3'd4,
    REG_LIMIT_LEVEL_SIX   = 3'd5,
    REG_LIMIT_LEVEL_SEVEN = 3'd6,
    REG_LIMIT_LEVEL_EIGHT = 3'd7
  } cfg_reg_t;

  typedef logic [NUM_LIMITS-1:0][DATA_WIDTH-1:0] limit_vec_t;

  // One finished segment handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] sum;
    logic [COUNT_WIDTH-1:0]      len;
    logic                        frame_end;
  } seg_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Back-end status.
  typedef struct packed {
    logic idle;
    logic dividing;
  } back_stat_t;

endpackage

>>> hdl/slmq_front.sv
// Sample accumulator: sums samples per segment and emits finished segments.
module slmq_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic signed [slmq_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                             in_frame_end,
  output logic                             in_full,
  input  logic [slmq_pkg::COUNT_WIDTH-1:0] seg_len,
  input  slmq_pkg::q_stat_t                q_stat,
  output logic                             job_push,
  output slmq_pkg::seg_job_t               job
);
  import slmq_pkg::*;

  localparam logic signed [SUM_WIDTH:0] SUM_MAX = (SUM_WIDTH+1)'((64'sd1 <<< (SUM_WIDTH-1)) - 1);
  localparam logic signed [SUM_WIDTH:0] SUM_MIN = -(SUM_WIDTH+1)'(64'sd1 <<< (SUM_WIDTH-1));

  logic signed [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0]      cnt_r, cnt_nxt;
  logic signed [SUM_WIDTH:0]   sum_add;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic [COUNT_WIDTH-1:0]      cnt_inc;
  logic [COUNT_WIDTH-1:0]      len_eff;
  logic                        accept;
  logic                        seg_done;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  // A zero length counts as one sample per segment.
  assign len_eff = (seg_len == '0) ? COUNT_WIDTH'(1) : seg_len;

  // Saturating add of the new sample.
  always_comb begin
    sum_add = (SUM_WIDTH+1)'(sum_r) + (SUM_WIDTH+1)'(in_sample);
    if (sum_add > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_WIDTH-1:0];
    end else if (sum_add < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      sum_sat = sum_add[SUM_WIDTH-1:0];
    end
  end

  assign cnt_inc  = cnt_r + COUNT_WIDTH'(1);
  assign seg_done = accept && (cnt_inc == len_eff);

  // Segment bookkeeping: a full segment or a frame end restarts the sum.
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (seg_done || in_frame_end) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_sat;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // The finished segment goes to the queue in the same cycle.
  assign job_push      = seg_done;
  assign job.sum       = sum_sat;
  assign job.len       = len_eff;
  assign job.frame_end = in_frame_end;

endmodule

>>> hdl/slmq_queue.sv
// Two-entry queue of finished segments between accumulator and divider.
module slmq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slmq_pkg::seg_job_t push_job,
  input  logic               pop,
  output slmq_pkg::seg_job_t pop_job,
  output slmq_pkg::q_stat_t  stat
);
  import slmq_pkg::*;

  seg_job_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_WIDTH-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = ent_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_WIDTH'(1);
      end
    end
  end

endmodule

>>> hdl/slmq_back.sv
// Divider and grader: one quotient bit per cycle, then level and output register.
module slmq_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  slmq_pkg::q_stat_t                q_stat,
  input  slmq_pkg::seg_job_t               job,
  output logic                             job_pop,
  input  slmq_pkg::limit_vec_t             limits,
  output slmq_pkg::back_stat_t             stat,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [slmq_pkg::LEVEL_WIDTH-1:0] out_level,
  output logic signed [slmq_pkg::MEAN_WIDTH-1:0] out_segment_mean,
  output logic                             out_frame_last
);
  import slmq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MEAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [SUM_WIDTH-1:0] POS_LIMIT = SUM_WIDTH'((64'd1 << (MEAN_WIDTH-1)) - 1);
  localparam logic [SUM_WIDTH-1:0] NEG_LIMIT = SUM_WIDTH'(64'd1 << (MEAN_WIDTH-1));

  state_t                        state_r, state_nxt;
  logic [SUM_WIDTH-1:0]          quo_r;
  logic [COUNT_WIDTH-1:0]        rem_r;
  logic [COUNT_WIDTH-1:0]        len_r;
  logic [STEP_WIDTH-1:0]         step_r;
  logic                          neg_r;
  logic                          fend_r;
  logic signed [MEAN_WIDTH-1:0]  mean_r;
  logic                          valid_r;
  logic [LEVEL_WIDTH-1:0]        level_r;
  logic signed [MEAN_WIDTH-1:0]  omean_r;
  logic                          oflast_r;
  logic [COUNT_WIDTH:0]          trial;
  logic [COUNT_WIDTH:0]          diff;
  logic                          ge;
  logic signed [MEAN_WIDTH-1:0]  mean_sat;
  logic [LEVEL_WIDTH-1:0]        level_c;
  logic                          out_slot;

  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.dividing = (state_r == ST_DIV);
  assign job_pop       = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_slot      = !valid_r || out_pop;

  // One restoring division step.
  assign trial = {rem_r, quo_r[SUM_WIDTH-1]};
  assign diff  = trial - {1'b0, len_r};
  assign ge    = (trial >= {1'b0, len_r});

  // Signed mean from the magnitude quotient, clamped to the output range.
  always_comb begin
    if (neg_r) begin
      mean_sat = (quo_r > NEG_LIMIT) ? -MEAN_WIDTH'(NEG_LIMIT) : -quo_r[MEAN_WIDTH-1:0];
    end else begin
      mean_sat = (quo_r > POS_LIMIT) ? MEAN_WIDTH'(POS_LIMIT) : quo_r[MEAN_WIDTH-1:0];
    end
  end

  // Grade: the level is the highest one whose threshold the mean exceeds.
  always_comb begin
    level_c = LEVEL_WIDTH'(1);
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (mean_r > $signed(limits[i])) begin
        level_c = LEVEL_WIDTH'(i + 2);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_stat.empty) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == '0) state_nxt = ST_MEAN;
      ST_MEAN: state_nxt = ST_OUT;
      ST_OUT:  if (out_slot) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      neg_r  <= job.sum[SUM_WIDTH-1];
      quo_r  <= job.sum[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - job.sum) : job.sum;
      len_r  <= job.len;
      fend_r <= job.frame_end;
      rem_r  <= '0;
      step_r <= STEP_WIDTH'(SUM_WIDTH - 1);
    end else if (state_r == ST_DIV) begin
      quo_r  <= {quo_r[SUM_WIDTH-2:0], ge};
      rem_r  <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      step_r <= step_r - STEP_WIDTH'(1);
    end
    if (state_r == ST_MEAN) begin
      mean_r <= mean_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_slot) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_slot) begin
      level_r  <= level_c;
      omean_r  <= mean_r;
      oflast_r <= fend_r;
    end
  end

  assign out_empty        = !valid_r;
  assign out_level        = level_r;
  assign out_segment_mean = omean_r;
  assign out_frame_last   = oflast_r;

endmodule

>>> hdl/segment_mean_level_quantizer.sv
// Top level of the segment mean level meter.
// Usage: samples enter on a queue-like port (in_push, in_full). An item is
// taken at a clock edge where in_push is high and in_full is low, one per
// cycle while the segment queue has room. Every segment_length samples the
// accumulated sum moves into a two-entry segment queue; a frame end in the
// middle of a segment drops the partial sum without a result.
// Results leave on a queue-like port (out_empty, out_pop): the oldest result
// waits on out_level, out_segment_mean and out_frame_last while out_empty is
// low and is taken at an edge where out_pop is high.
// Path: with the divider and the output register free, a segment's sum goes
// from its queue entry through the divider states (load, divide, mean,
// grade) into the output register. The divider makes one quotient bit per
// cycle and takes a new segment only when idle, so a burst of short segments
// fills the queue and in_full then holds off samples until it frees an entry.
// When the receiver stalls, one result waits in the output register, the
// divider holds its next result and the queue fills behind it.
// Configuration: cfg_valid with cfg_index and cfg_data writes a register;
// cfg_ready is always high. Write only while no segment is in flight.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the running sum, the sample count, the queue and the output register.
`include "segment_mean_level_quantizer_assert.svh"
module segment_mean_level_quantizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [slmq_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                             in_frame_end,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [slmq_pkg::LEVEL_WIDTH-1:0] out_level,
  output logic signed [slmq_pkg::MEAN_WIDTH-1:0] out_segment_mean,
  output logic                             out_frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slmq_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  logic [slmq_pkg::DATA_WIDTH-1:0]  cfg_data
);
  import slmq_pkg::*;

  logic [COUNT_WIDTH-1:0] seg_len_r;
  limit_vec_t             limits_r;
  q_stat_t                q_stat;
  back_stat_t             back_stat;
  seg_job_t               push_job, pop_job;
  logic                   job_push, job_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r <= SEG_LEN_RESET;
      limits_r  <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEGMENT_LENGTH:    seg_len_r   <= COUNT_WIDTH'(cfg_data);
        REG_LIMIT_LEVEL_TWO:   limits_r[0] <= cfg_data;
        REG_LIMIT_LEVEL_THREE: limits_r[1] <= cfg_data;
        REG_LIMIT_LEVEL_FOUR:  limits_r[2] <= cfg_data;
        REG_LIMIT_LEVEL_FIVE:  limits_r[3] <= cfg_data;
        REG_LIMIT_LEVEL_SIX:   limits_r[4] <= cfg_data;
        REG_LIMIT_LEVEL_SEVEN: limits_r[5] <= cfg_data;
        REG_LIMIT_LEVEL_EIGHT: limits_r[6] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accumulator front end.
  slmq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_sample    (in_sample),
    .in_frame_end (in_frame_end),
    .in_full      (in_full),
    .seg_len      (seg_len_r),
    .q_stat       (q_stat),
    .job_push     (job_push),
    .job          (push_job)
  );

  // Segment queue.
  slmq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // Divider, grader and output register.
  slmq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .job              (pop_job),
    .job_pop          (job_pop),
    .limits           (limits_r),
    .stat             (back_stat),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_level        (out_level),
    .out_segment_mean (out_segment_mean),
    .out_frame_last   (out_frame_last)
  );

  // The divider starts on a waiting segment in the next cycle.
  `SMLQ_ASSERT_NXT(a_back_starts, clk, rst_n, back_stat.idle && !q_stat.empty, back_stat.dividing)
  // The queue is only drained by an idle back end.
  `SMLQ_ASSERT_IMP(a_pop_when_idle, clk, rst_n, job_pop, back_stat.idle && !q_stat.empty)
  // An empty queue with no new segment stays empty.
  `SMLQ_ASSERT_NXT(a_queue_no_ghost, clk, rst_n, q_stat.empty && !job_push, q_stat.empty)

endmodule
